@@ src/crg_pkg.sv @@
package crg_pkg;

    localparam int TIME_W = 64;
    localparam int CFG_W  = 32;
    localparam int POS_W  = 16;
    localparam int SRC_W  = 3;
    localparam int IDX_W  = 3;

    // operation codes
    localparam logic [1:0] OP_SUBMIT   = 2'd0;
    localparam logic [1:0] OP_EVALUATE = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_FAIL    = 2'd3;

    // action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_MOVE  = 2'd1;
    localparam logic [1:0] ACT_LIMIT = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_COOLDOWN_ONE   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COOLDOWN_TWO   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_COOLDOWN_THREE = 3'd2;
    localparam logic [IDX_W-1:0] CFG_EXPIRY         = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MAX_POSITION   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_TOLERANCE      = 3'd5;
    localparam logic [IDX_W-1:0] CFG_STEP_SIZE      = 3'd6;

    typedef struct packed {
        logic [CFG_W-1:0] cooldown_one;
        logic [CFG_W-1:0] cooldown_two;
        logic [CFG_W-1:0] cooldown_three;
        logic [CFG_W-1:0] expiry;
        logic [POS_W-1:0] max_position;
        logic [POS_W-1:0] tolerance;
        logic [POS_W-1:0] step_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       action;
        logic [SRC_W-1:0] decision_source;
        logic [POS_W-1:0] goal_position;
        logic             pending_flag;
        logic [SRC_W-1:0] pending_from;
        logic [SRC_W-1:0] recent_from;
        logic             at_limit_flag;
    } result_t;

endpackage

@@ src/crg_cfg_regs.sv @@
module crg_cfg_regs
    import crg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cooldown_one   <= '0;
            cfg_reg.cooldown_two   <= '0;
            cfg_reg.cooldown_three <= '0;
            cfg_reg.expiry         <= '0;
            cfg_reg.max_position   <= '1;
            cfg_reg.tolerance      <= '0;
            cfg_reg.step_size      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COOLDOWN_ONE:   cfg_reg.cooldown_one   <= cfg_data;
                CFG_COOLDOWN_TWO:   cfg_reg.cooldown_two   <= cfg_data;
                CFG_COOLDOWN_THREE: cfg_reg.cooldown_three <= cfg_data;
                CFG_EXPIRY:         cfg_reg.expiry         <= cfg_data;
                CFG_MAX_POSITION:   cfg_reg.max_position   <= cfg_data[POS_W-1:0];
                CFG_TOLERANCE:      cfg_reg.tolerance      <= cfg_data[POS_W-1:0];
                CFG_STEP_SIZE:      cfg_reg.step_size      <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ src/crg_core.sv @@
module crg_core
    import crg_pkg::*;
#(
    parameter int NUM_SOURCES = 4,
    parameter int SENSOR_MAX  = 4095
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [1:0]        op,
    input  logic [SRC_W-1:0]  src,
    input  logic [TIME_W-1:0] now,
    input  logic              fg_avail,
    input  logic              fb_valid,
    input  logic [POS_W-1:0]  pos,
    input  cfg_t              cfg,
    output result_t           res
);

    localparam int SLOT_W = $clog2(NUM_SOURCES);
    localparam logic [SRC_W:0]   NUM_SRC_V  = (SRC_W+1)'(NUM_SOURCES);
    localparam logic [POS_W-1:0] SENSOR_MAX_V = POS_W'(SENSOR_MAX);

    logic              pending_reg, pending_next;
    logic [SRC_W-1:0]  pend_src_reg, pend_src_next;
    logic [SRC_W-1:0]  recent_src_reg, recent_src_next;
    logic              at_limit_reg, at_limit_next;
    logic [TIME_W-1:0] since_reg;
    logic [TIME_W-1:0] last_time_reg [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] seen_reg;

    logic              src_ok;
    logic [SLOT_W-1:0] slot;
    logic [CFG_W-1:0]  cooldown;
    logic [TIME_W:0]   cool_diff;
    logic              cool_block;
    logic [TIME_W:0]   age_diff;
    logic              lapsed;
    logic [POS_W-1:0]  limit;
    logic [POS_W-1:0]  headroom;
    logic              near_limit;
    logic [POS_W:0]    stepped;
    logic              accept_submit;
    logic              do_clear;

    assign src_ok = (src != '0) && ({1'b0, src} < NUM_SRC_V);
    assign slot   = src[SLOT_W-1:0];

    always_comb
    begin
        case (src)
            3'd1:    cooldown = cfg.cooldown_one;
            3'd2:    cooldown = cfg.cooldown_two;
            3'd3:    cooldown = cfg.cooldown_three;
            default: cooldown = '0;
        endcase
    end

    // borrow bit marks time running backward; then the cooldown does not block
    assign cool_diff  = {1'b0, now} - {1'b0, last_time_reg[slot]};
    assign cool_block = src_ok && seen_reg[slot] && !cool_diff[TIME_W]
                        && (cool_diff[TIME_W-1:0] < {{(TIME_W-CFG_W){1'b0}}, cooldown});

    assign age_diff = {1'b0, now} - {1'b0, since_reg};
    assign lapsed   = age_diff[TIME_W] || ((cfg.expiry != '0)
                      && (age_diff[TIME_W-1:0] >= {{(TIME_W-CFG_W){1'b0}}, cfg.expiry}));

    assign limit      = (cfg.max_position > SENSOR_MAX_V) ? SENSOR_MAX_V : cfg.max_position;
    assign headroom   = limit - pos;
    assign near_limit = (pos >= limit) || (headroom <= cfg.tolerance);
    assign stepped    = {1'b0, pos} + {1'b0, cfg.step_size};

    always_comb
    begin
        pending_next    = pending_reg;
        pend_src_next   = pend_src_reg;
        recent_src_next = recent_src_reg;
        at_limit_next   = at_limit_reg;
        accept_submit   = 1'b0;
        do_clear        = 1'b0;
        res.status          = ST_OK;
        res.action          = ACT_NONE;
        res.decision_source = '0;
        res.goal_position   = '0;

        case (op)
            OP_SUBMIT:
            begin
                if (!src_ok)
                    res.status = ST_INVALID;
                else if (cool_block || pending_reg)
                    res.status = ST_BUSY;
                else
                begin
                    accept_submit = 1'b1;
                    pending_next  = 1'b1;
                    pend_src_next = src;
                end
            end
            OP_EVALUATE:
            begin
                if (pending_reg)
                begin
                    if (lapsed)
                    begin
                        pending_next  = 1'b0;
                        pend_src_next = '0;
                    end
                    else if (fg_avail)
                    begin
                        pending_next  = 1'b0;
                        pend_src_next = '0;
                        if (!fb_valid || (pos > SENSOR_MAX_V))
                            res.status = ST_FAIL;
                        else
                        begin
                            res.decision_source = pend_src_reg;
                            recent_src_next     = pend_src_reg;
                            at_limit_next       = near_limit;
                            if (near_limit)
                            begin
                                res.action        = ACT_LIMIT;
                                res.goal_position = pos;
                            end
                            else
                            begin
                                res.action = ACT_MOVE;
                                res.goal_position = (stepped < {1'b0, limit})
                                                    ? stepped[POS_W-1:0] : limit;
                            end
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                do_clear        = 1'b1;
                pending_next    = 1'b0;
                pend_src_next   = '0;
                recent_src_next = '0;
                at_limit_next   = 1'b0;
            end
            default: ;
        endcase

        res.pending_flag  = pending_next;
        res.pending_from  = pend_src_next;
        res.recent_from   = recent_src_next;
        res.at_limit_flag = at_limit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            pend_src_reg   <= '0;
            recent_src_reg <= '0;
            at_limit_reg   <= 1'b0;
            seen_reg       <= '0;
        end
        else if (step)
        begin
            pending_reg    <= pending_next;
            pend_src_reg   <= pend_src_next;
            recent_src_reg <= recent_src_next;
            at_limit_reg   <= at_limit_next;
            if (do_clear)
                seen_reg <= '0;
            else if (accept_submit)
                seen_reg[slot] <= 1'b1;
        end
    end

    // timestamps are only read behind pending or a seen bit
    always_ff @(posedge clk)
    begin
        if (step && accept_submit)
        begin
            since_reg           <= now;
            last_time_reg[slot] <= now;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == (pend_src_reg != '0))
        else $error("pending flag and pending source disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && (op == OP_CLEAR) |=> !pending_reg && (recent_src_reg == '0)
                                     && !at_limit_reg && (seen_reg == '0))
        else $error("clear left runtime state behind");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && (res.status == ST_BUSY) |-> (op == OP_SUBMIT))
        else $error("busy reported outside a submit");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && accept_submit |-> !pending_reg && src_ok)
        else $error("request taken while another is pending");

endmodule

@@ src/cooldown_request_gate_position_step.sv @@
// An accepted request waits in the input register until the result register is free or draining.
// Throughput: one request per cycle unless out_ready stalls; the decision is one pass of
// compare/add logic between the input and result registers, with state updated in that pass.
// Reset (rst_n, async, active low): no request pending, all sources unseen,
// configuration registers at their reset values, both pipeline stages empty.
module cooldown_request_gate_position_step
    import crg_pkg::*;
#(
    parameter int NUM_SOURCES = 4,
    parameter int SENSOR_MAX  = 4095
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    input  logic [SRC_W-1:0]  source,
    input  logic [TIME_W-1:0] now_time,
    input  logic              foreground_free,
    input  logic              feedback_valid,
    input  logic [POS_W-1:0]  sensed_position,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [1:0]        action,
    output logic [SRC_W-1:0]  decision_source,
    output logic [POS_W-1:0]  goal_position,
    output logic              pending_flag,
    output logic [SRC_W-1:0]  pending_from,
    output logic [SRC_W-1:0]  recent_from,
    output logic              at_limit_flag
);

    cfg_t    cfg;
    result_t res_comb;
    result_t res_reg;

    logic              s1_valid_reg;
    logic [1:0]        op_reg;
    logic [SRC_W-1:0]  src_reg;
    logic [TIME_W-1:0] now_reg;
    logic              fg_reg;
    logic              fb_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              in_take;

    crg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crg_core #(
        .NUM_SOURCES (NUM_SOURCES),
        .SENSOR_MAX  (SENSOR_MAX)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .op       (op_reg),
        .src      (src_reg),
        .now      (now_reg),
        .fg_avail (fg_reg),
        .fb_valid (fb_reg),
        .pos      (pos_reg),
        .cfg      (cfg),
        .res      (res_comb)
    );

    // advance the held request whenever the result slot is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            src_reg <= source;
            now_reg <= now_time;
            fg_reg  <= foreground_free;
            fb_reg  <= feedback_valid;
            pos_reg <= sensed_position;
        end
        if (advance)
            res_reg <= res_comb;
    end

    assign out_valid       = out_valid_reg;
    assign status          = res_reg.status;
    assign action          = res_reg.action;
    assign decision_source = res_reg.decision_source;
    assign goal_position   = res_reg.goal_position;
    assign pending_flag    = res_reg.pending_flag;
    assign pending_from    = res_reg.pending_from;
    assign recent_from     = res_reg.recent_from;
    assign at_limit_flag   = res_reg.at_limit_flag;

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken with both stages full");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.action != ACT_NONE) |-> (res_reg.decision_source != '0)
                                                      && (res_reg.status == ST_OK))
        else $error("granted action without a source");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(res_reg))
        else $error("result changed while waiting");

endmodule
